// ----- design/wildcard_substring_matcher_core_defines.svh -----
// assertion macros for the wildcard substring matcher
// no dependencies; included by the matcher core, which carries the concurrent checks
`ifndef WILDCARD_SUBSTRING_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_SUBSTRING_MATCHER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// property checked outside reset
`define WSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked at every edge, reset included
`define WSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSM_ASSERT(lbl, clk, rstn, prop, msg)
`define WSM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/wsm_pkg.sv -----
`timescale 1ns / 1ps
// shared constants for the wildcard substring matcher
// no dependencies
package wsm_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;

  localparam logic [7:0] STAR_BYTE = 8'd42;
  localparam logic [7:0] END_BYTE  = 8'd0;

  typedef enum logic [1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } reg_idx_e;

endpackage

// ----- design/wsm_cfg.sv -----
`timescale 1ns / 1ps
// configuration registers: pattern bytes and length, effective pattern length
// depends on wsm_pkg
module wsm_cfg #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned LW          = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsm_pkg::ADDR_W-1:0]       paddr,
  input  logic [wsm_pkg::DATA_W-1:0]       pwdata,
  output logic [wsm_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  output logic [MAX_PATTERN-1:0][7:0]      pat_o,
  output logic [LW-1:0]                    eff_len_o
);

  logic [63:0] pat_lo_q;
  logic [63:0] pat_hi_q;
  logic [4:0]  pat_len_q;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic [127:0] pat_all;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];
  assign pat_all = {pat_hi_q, pat_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
    end else if (wr_en) begin
      case (wsm_pkg::reg_idx_e'(reg_idx))
        wsm_pkg::REG_PAT_LO:  pat_lo_q  <= pwdata;
        wsm_pkg::REG_PAT_HI:  pat_hi_q  <= pwdata;
        wsm_pkg::REG_PAT_LEN: pat_len_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wsm_pkg::reg_idx_e'(reg_idx))
      wsm_pkg::REG_PAT_LO:  prdata = pat_lo_q;
      wsm_pkg::REG_PAT_HI:  prdata = pat_hi_q;
      wsm_pkg::REG_PAT_LEN: prdata = {59'd0, pat_len_q};
      default:              prdata = '0;
    endcase
  end

  // bytes past the 16 held in the registers read as zero
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
    if (i < 16) begin : g_held
      assign pat_o[i] = pat_all[8*i +: 8];
    end else begin : g_none
      assign pat_o[i] = 8'd0;
    end
  end

  // saturate the length, then stop at the first zero byte
  always_comb begin
    if (int'(pat_len_q) > int'(MAX_PATTERN)) begin
      eff_len_o = LW'(MAX_PATTERN);
    end else begin
      eff_len_o = LW'(pat_len_q);
    end
    for (int i = int'(MAX_PATTERN) - 1; i >= 0; i--) begin
      if ((pat_o[i] == wsm_pkg::END_BYTE) && (i < int'(pat_len_q))) begin
        eff_len_o = LW'(i);
      end
    end
  end

endmodule

// ----- design/wsm_step.sv -----
`timescale 1ns / 1ps
// position-set update for one byte: star closure, byte match, sticky match
// depends on wsm_pkg
module wsm_step #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned LW          = 5
) (
  input  logic [MAX_PATTERN:0]         active_i,
  input  logic                         match_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [MAX_PATTERN-1:0][7:0]  pat_i,
  input  logic [LW-1:0]                eff_len_i,
  output logic [MAX_PATTERN:0]         active_o,
  output logic                         match_o,
  output logic                         found_o
);

  logic [MAX_PATTERN:0]   len_mask;
  logic [MAX_PATTERN:0]   prop;
  logic [MAX_PATTERN-1:0] star_in;
  logic [MAX_PATTERN-1:0] lit_hit;
  logic [MAX_PATTERN:0]   cur;
  logic [MAX_PATTERN:0]   nxt_raw;
  logic [MAX_PATTERN:0]   nxt;
  logic                   hit_cur;
  logic                   is_end;

  // prefix fill: a set position spreads upward across a run of stars
  function automatic logic [MAX_PATTERN:0] star_close(input logic [MAX_PATTERN:0] s,
                                                       input logic [MAX_PATTERN:0] p);
    logic [MAX_PATTERN:0] g;
    logic [MAX_PATTERN:0] t;
    g = s;
    t = p;
    for (int d = 1; d <= int'(MAX_PATTERN); d = d * 2) begin
      g = g | (t & (g << d));
      t = t & (t << d);
    end
    return g;
  endfunction

  always_comb begin
    len_mask = '0;
    prop     = '0;
    star_in  = '0;
    lit_hit  = '0;
    for (int q = 0; q <= int'(MAX_PATTERN); q++) begin
      len_mask[q] = (q <= int'(eff_len_i));
    end
    for (int p = 0; p < int'(MAX_PATTERN); p++) begin
      star_in[p]  = (p < int'(eff_len_i)) && (pat_i[p] == wsm_pkg::STAR_BYTE);
      lit_hit[p]  = (p < int'(eff_len_i)) && (pat_i[p] != wsm_pkg::STAR_BYTE)
                    && (pat_i[p] == data_byte_i);
      prop[p + 1] = star_in[p];
    end
  end

  assign is_end  = (data_byte_i == wsm_pkg::END_BYTE);
  assign cur     = star_close(active_i, prop) & len_mask;
  assign hit_cur = cur[eff_len_i];

  // stars hold their position, matching literals advance by one
  assign nxt_raw = {1'b0, cur[MAX_PATTERN-1:0] & star_in}
                 | {cur[MAX_PATTERN-1:0] & lit_hit, 1'b0}
                 | {{MAX_PATTERN{1'b0}}, 1'b1};
  assign nxt     = star_close(nxt_raw, prop) & len_mask;

  always_comb begin
    if (is_end) begin
      found_o  = match_i | hit_cur;
      // restart from the start position, closed over the leading stars
      active_o = star_close({{MAX_PATTERN{1'b0}}, 1'b1}, prop) & len_mask;
      match_o  = 1'b0;
    end else begin
      found_o  = match_i | hit_cur | nxt[eff_len_i];
      active_o = nxt;
      match_o  = found_o;
    end
  end

endmodule

// ----- design/wildcard_substring_matcher_core.sv -----
`timescale 1ns / 1ps
// wildcard substring matcher top level: input register, position state, result register
// depends on wsm_pkg, wsm_cfg, wsm_step and the assertion macro header
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o   | data_byte_i
//   out     | output    | out_valid_o / out_stall_i | found_o, string_done_o
//   cfg     | input     | psel, penable, pwrite    | paddr, pwdata, prdata
//
// one byte per cycle while no stalled result holds the flow; a byte's verdict goes from the input
// register into the result register, from which it can leave; the position update is one pass of
// shallow logic between the input register and the result register.
// reset clears the position set to the start position and clears the match flag.
// a stalled result holds; one more byte is still taken into the input register.
`include "wildcard_substring_matcher_core_defines.svh"
module wildcard_substring_matcher_core #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic                        string_done_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsm_pkg::ADDR_W-1:0]  paddr,
  input  logic [wsm_pkg::DATA_W-1:0]  pwdata,
  output logic [wsm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][7:0] pat;
  logic [LW-1:0]               eff_len;

  logic                 in_valid_q;
  logic [7:0]           data_q;
  logic [MAX_PATTERN:0] active_q;
  logic [MAX_PATTERN:0] active_d;
  logic                 match_q;
  logic                 match_d;
  logic                 found_d;
  logic                 out_valid_q;
  logic                 found_q;
  logic                 done_q;
  logic                 advance;

  wsm_cfg #(
    .MAX_PATTERN(MAX_PATTERN),
    .LW         (LW)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pat_o    (pat),
    .eff_len_o(eff_len)
  );

  wsm_step #(
    .MAX_PATTERN(MAX_PATTERN),
    .LW         (LW)
  ) u_step (
    .active_i   (active_q),
    .match_i    (match_q),
    .data_byte_i(data_q),
    .pat_i      (pat),
    .eff_len_i  (eff_len),
    .active_o   (active_d),
    .match_o    (match_d),
    .found_o    (found_d)
  );

  // the held byte moves on unless a result is already waiting and stalled
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & out_valid_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= {{MAX_PATTERN{1'b0}}, 1'b1};
      match_q  <= 1'b0;
    end else if (advance) begin
      active_q <= active_d;
      match_q  <= match_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q <= found_d;
      done_q  <= (data_q == wsm_pkg::END_BYTE);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign string_done_o = done_q;

  `WSM_ASSERT(a_end_clears, clk_i, rst_ni,
    (advance && data_q == wsm_pkg::END_BYTE) |=> (active_q[0] && !match_q),
    "terminator did not restart the position set")
  `WSM_ASSERT(a_match_sticky, clk_i, rst_ni,
    (advance && data_q != wsm_pkg::END_BYTE && match_q) |=> match_q,
    "match flag dropped within a string")
  `WSM_ASSERT(a_result_follows, clk_i, rst_ni,
    advance |=> out_valid_q,
    "advanced byte produced no result")
  `WSM_ASSERT(a_start_pos, clk_i, rst_ni,
    active_q[0],
    "start position missing from the position set")

endmodule

// ----- dv/wildcard_substring_matcher_checker.sv -----
`timescale 1ns / 1ps
// result checker for the wildcard substring matcher: follows register writes and byte
// transfers, keeps its own position set and compares every result transfer
// depends on wsm_pkg
module wildcard_substring_matcher_checker #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       found_i,
  input  logic                       string_done_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [wsm_pkg::ADDR_W-1:0] paddr_i,
  input  logic [wsm_pkg::DATA_W-1:0] pwdata_i,
  input  logic                       pready_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic found;
    logic done;
  } verdict_t;

  logic [7:0]           pat_mem [MAX_PATTERN];
  logic [4:0]           pat_len_reg;
  logic [MAX_PATTERN:0] pos_set;
  logic                 hit_flag;
  verdict_t             verdict_q [$];
  int                   fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns  matcher check: %s", $time, msg);
    end
    fail_count++;
  endtask

  // pattern length as seen by the matcher: saturated, cut at the first zero byte
  function automatic int unsigned live_length();
    int unsigned n;
    n = (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg;
    for (int unsigned i = 0; i < n; i++)
      if (pat_mem[i] == wsm_pkg::END_BYTE) return i;
    return n;
  endfunction

  function automatic logic [MAX_PATTERN:0] close_stars(input logic [MAX_PATTERN:0] s,
                                                        input int unsigned len);
    logic [MAX_PATTERN:0] r;
    r = s;
    for (int unsigned p = 0; p < len; p++)
      if (r[p] && pat_mem[p] == wsm_pkg::STAR_BYTE) r[p+1] = 1'b1;
    for (int unsigned p = len + 1; p <= MAX_PATTERN; p++)
      r[p] = 1'b0;
    return r;
  endfunction

  function automatic void restart_matcher();
    pos_set    = '0;
    pos_set[0] = 1'b1;
    hit_flag   = 1'b0;
    pos_set    = close_stars(pos_set, live_length());
  endfunction

  function automatic void apply_write(input logic [wsm_pkg::ADDR_W-1:0] addr,
                                      input logic [wsm_pkg::DATA_W-1:0] value);
    case (addr[wsm_pkg::ADDR_W-1:3])
      wsm_pkg::REG_PAT_LO: begin
        for (int k = 0; k < 8; k++)
          if (k < MAX_PATTERN) pat_mem[k] = value[8*k +: 8];
      end
      wsm_pkg::REG_PAT_HI: begin
        for (int k = 0; k < 8; k++)
          if (8 + k < MAX_PATTERN) pat_mem[8+k] = value[8*k +: 8];
      end
      wsm_pkg::REG_PAT_LEN: begin
        pat_len_reg = value[4:0];
      end
      default: ;
    endcase
  endfunction

  function automatic verdict_t advance_matcher(input logic [7:0] c);
    int unsigned          len;
    logic [MAX_PATTERN:0] nxt;
    verdict_t             v;
    len     = live_length();
    // pattern may have changed since the last byte
    pos_set = close_stars(pos_set, len);
    if (pos_set[len]) hit_flag = 1'b1;
    if (c == wsm_pkg::END_BYTE) begin
      v.found = hit_flag;
      v.done  = 1'b1;
      restart_matcher();
      return v;
    end
    nxt    = '0;
    nxt[0] = 1'b1;
    for (int unsigned p = 0; p < len; p++) begin
      if (pos_set[p]) begin
        if (pat_mem[p] == wsm_pkg::STAR_BYTE) nxt[p] = 1'b1;
        else if (pat_mem[p] == c) nxt[p+1] = 1'b1;
      end
    end
    pos_set = close_stars(nxt, len);
    if (pos_set[len]) hit_flag = 1'b1;
    v.found = hit_flag;
    v.done  = 1'b0;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PATTERN; i++) pat_mem[i] = 8'h00;
      pat_len_reg = '0;
      restart_matcher();
      verdict_q.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) apply_write(paddr_i, pwdata_i);
      if (in_valid_i && !in_stall_i) verdict_q.push_back(advance_matcher(data_byte_i));
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected (found %b done %b)",
                                    found_i, string_done_i));
        end else begin
          want = verdict_q.pop_front();
          if (found_i !== want.found)
            report_mismatch($sformatf("found is %b, expected %b", found_i, want.found));
          if (string_done_i !== want.done)
            report_mismatch($sformatf("string_done is %b, expected %b",
                                      string_done_i, want.done));
        end
      end
      pending_o <= verdict_q.size();
    end
  end

endmodule

// ----- dv/wildcard_substring_matcher_core_test.sv -----
`timescale 1ns / 1ps
// testbench top for wildcard_substring_matcher_core: clock, reset, register writes,
// byte strings and result stalls; checking is done in wildcard_substring_matcher_checker
// depends on wsm_pkg, the matcher core and the checker
module wildcard_substring_matcher_core_test;

  localparam int unsigned MAX_PATTERN = 16;
  localparam int          ITEM_TARGET = 1370;
  localparam int          CYCLE_LIMIT = 800000;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic [7:0]                 data_byte = 8'h00;
  logic                       out_stall = 1'b0;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [wsm_pkg::ADDR_W-1:0] paddr     = '0;
  logic [wsm_pkg::DATA_W-1:0] pwdata    = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic                       found;
  logic                       string_done;
  logic [wsm_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  int                fail_count;
  int                pending;
  int                cycle_cnt  = 0;
  int                n_items    = 0;
  int unsigned       idle_mode  = 0;
  int unsigned       stall_mode = 0;
  int unsigned       stall_left = 0;
  int unsigned       stall_roll;

  logic [7:0]        pat_img [16];
  logic [4:0]        pat_len_cfg;
  logic [7:0]        alpha [4];

  always #6 clk = ~clk;

  wildcard_substring_matcher_core #(
    .MAX_PATTERN(MAX_PATTERN)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .found_o       (found),
    .string_done_o (string_done),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  wildcard_substring_matcher_checker #(
    .MAX_PATTERN(MAX_PATTERN)
  ) checker_inst (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .data_byte_i   (data_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .found_i       (found),
    .string_done_i (string_done),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** wildcard_substring_matcher_core: FAILED **");
      $finish;
    end
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_mode == 0 || stall_roll < ((stall_mode == 1) ? 75 : 40)) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (stall_roll < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < ((idle_mode == 1) ? 75 : 45)) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    n_items++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // block quiet: every result back, input register empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [wsm_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_pattern();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat_img[i];
      hi[8*i +: 8] = pat_img[8+i];
    end
    // upper bits of the length word are don't-care
    len_word      = {$urandom, $urandom};
    len_word[4:0] = pat_len_cfg;
    apb_write(wsm_pkg::REG_PAT_LO, lo);
    apb_write(wsm_pkg::REG_PAT_HI, hi);
    apb_write(wsm_pkg::REG_PAT_LEN, len_word);
  endtask

  task automatic fill_pattern(input string s, input logic [4:0] len);
    for (int i = 0; i < 16; i++)
      pat_img[i] = (i < s.len()) ? s[i] : 8'($urandom_range(0, 255));
    pat_len_cfg = len;
  endtask

  function automatic logic [7:0] text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return alpha[$urandom_range(0, 3)];
    if (r < 92) return wsm_pkg::STAR_BYTE;
    return 8'($urandom_range(1, 255));
  endfunction

  // random prefix, mostly an instance of the pattern with stars expanded, random suffix
  task automatic send_string(input bit terminate);
    int unsigned span;
    int unsigned lim;
    logic [7:0]  b;
    lim  = (pat_len_cfg > 16) ? 16 : pat_len_cfg;
    span = lim;
    for (int unsigned i = 0; i < lim; i++) begin
      if (pat_img[i] == wsm_pkg::END_BYTE && span == lim) span = i;
    end
    repeat ($urandom_range(0, 5)) send_byte(text_byte());
    if ($urandom_range(0, 3) != 0) begin
      for (int unsigned i = 0; i < span; i++) begin
        if (pat_img[i] == wsm_pkg::STAR_BYTE) begin
          repeat ($urandom_range(0, 3)) send_byte(text_byte());
        end else begin
          b = pat_img[i];
          // occasional corrupted instance
          if ($urandom_range(0, 15) == 0) b = text_byte();
          send_byte(b);
        end
      end
    end
    repeat ($urandom_range(0, 4)) send_byte(text_byte());
    if (terminate) send_byte(wsm_pkg::END_BYTE);
  endtask

  task automatic build_random_pattern();
    int unsigned roll;
    int unsigned r;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       pat_len_cfg = 5'd0;
      1:       pat_len_cfg = 5'd16;
      2:       pat_len_cfg = 5'($urandom_range(17, 31));
      default: pat_len_cfg = 5'($urandom_range(1, 6));
    endcase
    for (int i = 0; i < 16; i++) begin
      r = $urandom_range(0, 99);
      if (roll == 3) pat_img[i] = wsm_pkg::STAR_BYTE;
      else if (r < 25) pat_img[i] = wsm_pkg::STAR_BYTE;
      else if (r < 95) pat_img[i] = alpha[$urandom_range(0, 3)];
      else pat_img[i] = 8'($urandom_range(0, 255));
    end
    // zero byte cuts the pattern short
    if (pat_len_cfg != 0 && $urandom_range(0, 7) == 0)
      pat_img[$urandom_range(0, (pat_len_cfg > 16) ? 15 : pat_len_cfg - 1)] = wsm_pkg::END_BYTE;
  endtask

  initial begin
    int unsigned n_str;
    alpha[0] = "a";
    alpha[1] = "b";
    alpha[2] = "c";
    alpha[3] = 8'hFF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern after reset: matches from the first byte, terminator included
    send_byte(wsm_pkg::END_BYTE);
    send_byte(8'hFF);
    send_byte(wsm_pkg::STAR_BYTE);
    send_byte(wsm_pkg::END_BYTE);

    // star spans a literal star in the text
    wait_idle();
    fill_pattern("a*b", 5'd3);
    program_pattern();
    send_byte("a");
    send_byte(wsm_pkg::STAR_BYTE);
    send_byte("b");
    send_byte(wsm_pkg::END_BYTE);

    // zero byte inside the pattern ends it
    wait_idle();
    fill_pattern("axb", 5'd3);
    pat_img[1] = wsm_pkg::END_BYTE;
    program_pattern();
    send_text("a");
    send_byte(wsm_pkg::END_BYTE);

    // stars only
    wait_idle();
    fill_pattern("**", 5'd2);
    program_pattern();
    send_byte(wsm_pkg::END_BYTE);

    // length above the maximum saturates; unknown register is ignored
    wait_idle();
    fill_pattern("***************q", 5'd31);
    program_pattern();
    apb_write(REG_UNUSED, {$urandom, $urandom});
    send_text("q");
    send_byte(wsm_pkg::END_BYTE);

    // pattern changed in the middle of a string keeps the positions
    wait_idle();
    fill_pattern("ab", 5'd2);
    program_pattern();
    send_text("a");
    wait_idle();
    pat_img[0] = "x";
    program_pattern();
    send_text("b");
    send_byte(wsm_pkg::END_BYTE);

    while (n_items < ITEM_TARGET) begin
      wait_idle();
      idle_mode  = $urandom_range(0, 2);
      stall_mode = $urandom_range(0, 2);
      for (int k = 0; k < 4; k++) begin
        do alpha[k] = 8'($urandom_range(1, 255)); while (alpha[k] == wsm_pkg::STAR_BYTE);
      end
      build_random_pattern();
      program_pattern();
      if ($urandom_range(0, 9) == 0) apb_write(REG_UNUSED, {$urandom, $urandom});
      n_str = $urandom_range(2, 6);
      // the last string of a phase is sometimes left open across the next write
      for (int unsigned s = 0; s < n_str; s++)
        send_string(s + 1 < n_str || $urandom_range(0, 3) != 0);
    end

    wait_idle();
    send_byte(wsm_pkg::END_BYTE);
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** wildcard_substring_matcher_core: PASSED **");
    end else begin
      $display("** wildcard_substring_matcher_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/wsm_pkg.sv
design/wsm_cfg.sv
design/wsm_step.sv
design/wildcard_substring_matcher_core.sv
dv/wildcard_substring_matcher_checker.sv
dv/wildcard_substring_matcher_core_test.sv
